// ----- rtl/dlm_pkg.sv -----
// Shared types and codes for the dense-layer matrix engine.
package dlm_pkg;

  typedef enum logic [1:0] {
    REQ_LOAD_A  = 2'd0,
    REQ_LOAD_B  = 2'd1,
    REQ_COMPUTE = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    MODE_FWD   = 2'd0,
    MODE_IGRAD = 2'd1,
    MODE_WGRAD = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_LOAD_A  = 2'd0,
    KIND_LOAD_B  = 2'd1,
    KIND_COMPUTE = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_e;

  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_ROWS  = 2'd1;
  localparam logic [1:0] CFG_INNER = 2'd2;
  localparam logic [1:0] CFG_COLS  = 2'd3;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  localparam int CFG_DATA_W = 5;
  localparam int SUM_W      = 36;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [3:0]        row_index;
    logic [3:0]        col_index;
    logic signed [15:0] element_value;
  } req_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] dot_sum;
    logic                    status;
  } rsp_t;

endpackage

// ----- rtl/dense_layer_matmul_three_mode.sv -----
// Top level of the dense-layer matrix engine: front end, item queue, back end.
//
//  channel   | signals                                   | transfer
//  ----------+-------------------------------------------+------------------------------
//  request   | start, busy, req_i                        | start && !busy
//  config    | cfg_valid_i, cfg_ready_o, cfg_index_i/data | cfg_valid_i && cfg_ready_o
//  result    | done_o, rsp_o                             | done_o, one cycle, no stall
//
// A load holds the back end only while it is popped; an error or empty sum answers via
// the queue and done registers. A compute holds it through the pop, trip reads with
// trip = K, M or N by mode, and two MAC stages; its sum leaves via the done register.
// Items wait in a two-entry queue; busy rises only when it is full. Reset clears control
// and configuration, not the operand stores. The receiver of results cannot stall.
module dense_layer_matmul_three_mode #(
  parameter int MAX_DIM   = 16,
  parameter int ELEM_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  dlm_pkg::req_t                  req_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [1:0]                     cfg_index_i,
  input  logic [dlm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                           done_o,
  output dlm_pkg::rsp_t                  rsp_o
);
  import dlm_pkg::*;

  localparam int AW       = $clog2(MAX_DIM * MAX_DIM);
  localparam int CW_RAW   = $clog2(MAX_DIM + 1);
  localparam int CW       = (CW_RAW > CFG_DATA_W) ? CW_RAW : CFG_DATA_W;
  localparam int Q_DEPTH  = 2;

  typedef struct packed {
    kind_e                kind;
    logic [AW-1:0]        addr_a;
    logic [AW-1:0]        addr_b;
    logic                 a_row_step;
    logic                 b_row_step;
    logic [CW-1:0]        trip;
    logic [ELEM_BITS-1:0] elem;
  } item_t;

  item_t front_item, back_item;
  logic  push, pop, q_valid, q_full;

  dlm_front #(.MAX_DIM(MAX_DIM), .ELEM_BITS(ELEM_BITS), .item_t(item_t)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .item_o      (front_item)
  );

  dlm_queue #(.DEPTH(Q_DEPTH), .item_t(item_t)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .item_o  (back_item)
  );

  dlm_back #(.MAX_DIM(MAX_DIM), .ELEM_BITS(ELEM_BITS), .item_t(item_t)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (back_item),
    .pop_o     (pop),
    .done_o    (done_o),
    .rsp_o     (rsp_o)
  );

endmodule

// ----- rtl/dlm_ram.sv -----
// Generic simple dual-port RAM, one write port and one registered read port.
module dlm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/dlm_front.sv -----
// Front end: configuration registers, request decode, bounds checks, address setup.
module dlm_front #(
  parameter int  MAX_DIM   = 16,
  parameter int  ELEM_BITS = 16,
  parameter type item_t    = logic
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  dlm_pkg::req_t                       req_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [1:0]                          cfg_index_i,
  input  logic [dlm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                q_full_i,
  output logic                                push_o,
  output item_t                               item_o
);
  import dlm_pkg::*;

  localparam int AW     = $clog2(MAX_DIM * MAX_DIM);
  localparam int CW_RAW = $clog2(MAX_DIM + 1);
  localparam int CW     = (CW_RAW > CFG_DATA_W) ? CW_RAW : CFG_DATA_W;

  logic [1:0]            mode_q;
  logic [CFG_DATA_W-1:0] rows_q, inner_q, cols_q;
  logic [CW-1:0]         dim_m, dim_k, dim_n;
  logic [AW-1:0]         row_base, col_base, row_a, col_a;
  logic                  accept, in_store, ok;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_FWD;
      rows_q  <= CFG_DATA_W'(16);
      inner_q <= CFG_DATA_W'(16);
      cols_q  <= CFG_DATA_W'(16);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MODE:  mode_q  <= cfg_data_i[1:0];
        CFG_ROWS:  rows_q  <= cfg_data_i;
        CFG_INNER: inner_q <= cfg_data_i;
        CFG_COLS:  cols_q  <= cfg_data_i;
        default:   mode_q  <= mode_q;
      endcase
    end
  end

  assign dim_m = (32'(rows_q) > MAX_DIM) ? CW'(MAX_DIM) : CW'(rows_q);
  assign dim_k = (32'(inner_q) > MAX_DIM) ? CW'(MAX_DIM) : CW'(inner_q);
  assign dim_n = (32'(cols_q) > MAX_DIM) ? CW'(MAX_DIM) : CW'(cols_q);

  assign row_a    = AW'(req_i.row_index);
  assign col_a    = AW'(req_i.col_index);
  assign row_base = AW'(row_a * AW'(MAX_DIM));
  assign col_base = AW'(col_a * AW'(MAX_DIM));
  assign in_store = (32'(req_i.row_index) < MAX_DIM) && (32'(req_i.col_index) < MAX_DIM);

  assign busy   = q_full_i;
  assign accept = start && !q_full_i;

  always_comb begin
    item_o            = '0;
    item_o.elem       = ELEM_BITS'($unsigned(req_i.element_value));
    item_o.addr_a     = AW'(row_base + col_a);
    item_o.addr_b     = AW'(row_base + col_a);
    push_o            = 1'b0;
    ok                = 1'b0;
    case (req_type_e'(req_i.req_type))
      REQ_LOAD_A: begin
        item_o.kind = KIND_LOAD_A;
        push_o      = accept && in_store;
      end
      REQ_LOAD_B: begin
        item_o.kind = KIND_LOAD_B;
        push_o      = accept && in_store;
      end
      REQ_COMPUTE: begin
        push_o = accept;
        case (mode_e'(mode_q))
          MODE_FWD: begin
            ok                = (req_i.row_index < dim_m) && (req_i.col_index < dim_n);
            item_o.addr_a     = row_base;
            item_o.a_row_step = 1'b0;
            item_o.addr_b     = col_a;
            item_o.b_row_step = 1'b1;
            item_o.trip       = dim_k;
          end
          MODE_IGRAD: begin
            ok                = (req_i.row_index < dim_k) && (req_i.col_index < dim_n);
            item_o.addr_a     = row_a;
            item_o.a_row_step = 1'b1;
            item_o.addr_b     = col_a;
            item_o.b_row_step = 1'b1;
            item_o.trip       = dim_m;
          end
          MODE_WGRAD: begin
            ok                = (req_i.row_index < dim_m) && (req_i.col_index < dim_k);
            item_o.addr_a     = row_base;
            item_o.a_row_step = 1'b0;
            item_o.addr_b     = col_base;
            item_o.b_row_step = 1'b0;
            item_o.trip       = dim_n;
          end
          default: ok = 1'b0;
        endcase
        item_o.kind = ok ? KIND_COMPUTE : KIND_ERROR;
      end
      default: push_o = 1'b0;
    endcase
  end

endmodule

// ----- rtl/dlm_queue.sv -----
// Small FIFO of decoded items between front end and back end.
module dlm_queue #(
  parameter int  DEPTH  = 2,
  parameter type item_t = logic
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output logic  valid_o,
  output logic  full_o,
  output item_t item_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  item_t         mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [NW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == NW'(DEPTH);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + NW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - NW'(1);
      end
    end
  end

endmodule

// ----- rtl/dlm_back.sv -----
// Back end: operand stores, load writes and the multiply-accumulate sequencer.
module dlm_back #(
  parameter int  MAX_DIM   = 16,
  parameter int  ELEM_BITS = 16,
  parameter type item_t    = logic
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  item_t         q_item_i,
  output logic          pop_o,
  output logic          done_o,
  output dlm_pkg::rsp_t rsp_o
);
  import dlm_pkg::*;

  localparam int AW     = $clog2(MAX_DIM * MAX_DIM);
  localparam int CW_RAW = $clog2(MAX_DIM + 1);
  localparam int CW     = (CW_RAW > CFG_DATA_W) ? CW_RAW : CFG_DATA_W;
  localparam int PW     = 2 * ELEM_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_e;

  state_e                 state_q;
  logic [AW-1:0]          a_addr_q, b_addr_q;
  logic                   a_row_step_q, b_row_step_q;
  logic [CW-1:0]          cnt_q;
  logic                   rd_v_q, rd_last_q, prod_v_q, prod_last_q;
  logic signed [PW-1:0]   prod_q;
  logic signed [SUM_W-1:0] acc_q, sum;
  logic                   done_q;
  rsp_t                   rsp_q;
  logic [ELEM_BITS-1:0]   a_data, b_data;
  logic                   we_a, we_b;

  assign pop_o = (state_q == ST_IDLE) && q_valid_i;
  assign we_a  = pop_o && (q_item_i.kind == KIND_LOAD_A);
  assign we_b  = pop_o && (q_item_i.kind == KIND_LOAD_B);

  dlm_ram #(.WIDTH(ELEM_BITS), .DEPTH(MAX_DIM * MAX_DIM)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (q_item_i.addr_a),
    .wdata_i (q_item_i.elem),
    .raddr_i (a_addr_q),
    .rdata_o (a_data)
  );

  dlm_ram #(.WIDTH(ELEM_BITS), .DEPTH(MAX_DIM * MAX_DIM)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (q_item_i.addr_b),
    .wdata_i (q_item_i.elem),
    .raddr_i (b_addr_q),
    .rdata_o (b_data)
  );

  assign sum    = acc_q + SUM_W'(prod_q);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      a_addr_q     <= '0;
      b_addr_q     <= '0;
      a_row_step_q <= 1'b0;
      b_row_step_q <= 1'b0;
      cnt_q        <= '0;
      rd_v_q       <= 1'b0;
      rd_last_q    <= 1'b0;
      prod_v_q     <= 1'b0;
      prod_last_q  <= 1'b0;
      prod_q       <= '0;
      acc_q        <= '0;
      done_q       <= 1'b0;
      rsp_q        <= '0;
    end else begin
      done_q      <= 1'b0;
      rd_v_q      <= state_q == ST_RUN;
      rd_last_q   <= (state_q == ST_RUN) && (cnt_q == CW'(1));
      prod_v_q    <= rd_v_q;
      prod_last_q <= rd_v_q && rd_last_q;
      prod_q      <= $signed(a_data) * $signed(b_data);
      if (prod_v_q) begin
        acc_q <= sum;
      end
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            a_addr_q     <= q_item_i.addr_a;
            b_addr_q     <= q_item_i.addr_b;
            a_row_step_q <= q_item_i.a_row_step;
            b_row_step_q <= q_item_i.b_row_step;
            cnt_q        <= q_item_i.trip;
            acc_q        <= '0;
            if (q_item_i.kind == KIND_ERROR) begin
              done_q        <= 1'b1;
              rsp_q.dot_sum <= '0;
              rsp_q.status  <= STATUS_RANGE;
            end else if (q_item_i.kind == KIND_COMPUTE) begin
              if (q_item_i.trip == '0) begin
                done_q        <= 1'b1;
                rsp_q.dot_sum <= '0;
                rsp_q.status  <= STATUS_OK;
              end else begin
                state_q <= ST_RUN;
              end
            end
          end
        end
        ST_RUN: begin
          a_addr_q <= a_addr_q + (a_row_step_q ? AW'(MAX_DIM) : AW'(1));
          b_addr_q <= b_addr_q + (b_row_step_q ? AW'(MAX_DIM) : AW'(1));
          cnt_q    <= cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (prod_last_q) begin
            done_q        <= 1'b1;
            rsp_q.dot_sum <= sum;
            rsp_q.status  <= STATUS_OK;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
